### sv/ms_pkg.sv
// Shared types and constants for the merge sorter.
// Used by ms_store, ms_seq and merge_sorter; depends on nothing.
`timescale 1ns / 1ps

package ms_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CNT_W:0]           sum_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_RUN,
    ST_M_RD,
    ST_M_WR,
    ST_O_RD,
    ST_O_WR
  } state_e;

  // Request to the two memories; sel 0 names memory A, 1 names memory B.
  typedef struct packed {
    logic  we;
    logic  wsel;
    addr_t waddr;
    data_t wdata;
    logic  rsel;
    addr_t raddr0;
    addr_t raddr1;
  } mem_req_t;

  typedef struct packed {
    logic  valid;
    data_t value;
    logic  last;
    logic  trunc;
  } res_t;

endpackage

### sv/ms_store.sv
// Two DEPTH x 32 memories (element store and merge scratch) with one write
// port and two registered read ports. Depends on ms_pkg.
`timescale 1ns / 1ps

module ms_store (
  input  logic             clk_i,
  input  ms_pkg::mem_req_t req_i,
  output ms_pkg::data_t    rdata0_o,
  output ms_pkg::data_t    rdata1_o
);

  ms_pkg::data_t mem_a [ms_pkg::DEPTH];
  ms_pkg::data_t mem_b [ms_pkg::DEPTH];
  ms_pkg::data_t rdata0_q;
  ms_pkg::data_t rdata1_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we && !req_i.wsel) begin
      mem_a[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.we && req_i.wsel) begin
      mem_b[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_q <= req_i.rsel ? mem_b[req_i.raddr0] : mem_a[req_i.raddr0];
    rdata1_q <= req_i.rsel ? mem_b[req_i.raddr1] : mem_a[req_i.raddr1];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

### sv/ms_seq.sv
// Load, merge-pass and readout sequencer of the merge sorter.
// Drives ms_store through a mem_req_t; depends on ms_pkg.
`timescale 1ns / 1ps

module ms_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ms_pkg::data_t    value_i,
  input  logic             last_i,
  output ms_pkg::mem_req_t req_o,
  input  ms_pkg::data_t    rdata0_i,
  input  ms_pkg::data_t    rdata1_i,
  output ms_pkg::res_t     res_o,
  input  logic             res_ready_i
);

  ms_pkg::state_e state_q, state_d;
  ms_pkg::cnt_t   cnt_q, cnt_d;
  logic           drop_q, drop_d;
  ms_pkg::cnt_t   w_q, w_d;
  ms_pkg::cnt_t   lo_q, lo_d;
  ms_pkg::cnt_t   mid_q, mid_d;
  ms_pkg::cnt_t   hi_q, hi_d;
  ms_pkg::cnt_t   a_q, a_d;
  ms_pkg::cnt_t   b_q, b_d;
  ms_pkg::cnt_t   k_q, k_d;
  ms_pkg::cnt_t   i_q, i_d;
  logic           src_q, src_d;

  ms_pkg::sum_t mid_sum, hi_sum;
  ms_pkg::cnt_t k_inc, i_inc;
  logic         take_left;
  logic         out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ms_pkg::ST_LOAD;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      w_q     <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      k_q     <= '0;
      i_q     <= '0;
      src_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      w_q     <= w_d;
      lo_q    <= lo_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      a_q     <= a_d;
      b_q     <= b_d;
      k_q     <= k_d;
      i_q     <= i_d;
      src_q   <= src_d;
    end
  end

  // Run bounds, clipped to the element count.
  assign mid_sum = {1'b0, lo_q} + {1'b0, w_q};
  assign hi_sum  = mid_sum + {1'b0, w_q};
  assign k_inc   = k_q + ms_pkg::cnt_t'(1);
  assign i_inc   = i_q + ms_pkg::cnt_t'(1);
  assign out_last = (i_inc == cnt_q);
  // Left run wins ties, so equal values keep their run order.
  assign take_left = (a_q < mid_q) && ((b_q >= hi_q) || (rdata0_i <= rdata1_i));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    w_d     = w_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    i_d     = i_q;
    src_d   = src_q;

    in_ready_o   = 1'b0;
    req_o        = '0;
    req_o.rsel   = src_q;
    req_o.raddr0 = a_q[ms_pkg::ADDR_W-1:0];
    req_o.raddr1 = b_q[ms_pkg::ADDR_W-1:0];
    res_o        = '0;

    case (state_q)
      ms_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < ms_pkg::cnt_t'(ms_pkg::DEPTH)) begin
            req_o.we    = 1'b1;
            req_o.wsel  = 1'b0;
            req_o.waddr = cnt_q[ms_pkg::ADDR_W-1:0];
            req_o.wdata = value_i;
            cnt_d       = cnt_q + ms_pkg::cnt_t'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_i) begin
            w_d     = ms_pkg::cnt_t'(1);
            src_d   = 1'b0;
            state_d = ms_pkg::ST_PASS;
          end
        end
      end

      ms_pkg::ST_PASS: begin
        if (w_q >= cnt_q) begin
          i_d     = '0;
          state_d = ms_pkg::ST_O_RD;
        end else begin
          lo_d    = '0;
          state_d = ms_pkg::ST_RUN;
        end
      end

      ms_pkg::ST_RUN: begin
        mid_d   = (mid_sum < {1'b0, cnt_q}) ? mid_sum[ms_pkg::CNT_W-1:0] : cnt_q;
        hi_d    = (hi_sum < {1'b0, cnt_q}) ? hi_sum[ms_pkg::CNT_W-1:0] : cnt_q;
        a_d     = lo_q;
        b_d     = mid_d;
        k_d     = lo_q;
        state_d = ms_pkg::ST_M_RD;
      end

      ms_pkg::ST_M_RD: begin
        state_d = ms_pkg::ST_M_WR;
      end

      ms_pkg::ST_M_WR: begin
        req_o.we    = 1'b1;
        req_o.wsel  = !src_q;
        req_o.waddr = k_q[ms_pkg::ADDR_W-1:0];
        req_o.wdata = take_left ? rdata0_i : rdata1_i;
        if (take_left) begin
          a_d = a_q + ms_pkg::cnt_t'(1);
        end else begin
          b_d = b_q + ms_pkg::cnt_t'(1);
        end
        k_d = k_inc;
        if (k_inc == hi_q) begin
          if (hi_q == cnt_q) begin
            w_d     = w_q << 1;
            src_d   = !src_q;
            state_d = ms_pkg::ST_PASS;
          end else begin
            lo_d    = hi_q;
            state_d = ms_pkg::ST_RUN;
          end
        end else begin
          state_d = ms_pkg::ST_M_RD;
        end
      end

      ms_pkg::ST_O_RD: begin
        req_o.raddr0 = i_q[ms_pkg::ADDR_W-1:0];
        state_d      = ms_pkg::ST_O_WR;
      end

      ms_pkg::ST_O_WR: begin
        req_o.raddr0 = i_q[ms_pkg::ADDR_W-1:0];
        res_o.valid  = 1'b1;
        res_o.value  = rdata0_i;
        res_o.last   = out_last;
        res_o.trunc  = drop_q;
        if (res_ready_i) begin
          if (out_last) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = ms_pkg::ST_LOAD;
          end else begin
            i_d     = i_inc;
            state_d = ms_pkg::ST_O_RD;
          end
        end
      end

      default: begin
        state_d = ms_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

### sv/merge_sorter.sv
// Merge sorter top level. Load: items are written to the store. Sort: ceil(log2 n)
// merge passes, each a series of read/compare/write merge steps (two reads and
// one write per merge step). Readout: each result is read from the store into the output register.
// Reset (rst_ni, async, active low) empties the run; memories are not cleared.
// Depends on ms_pkg, ms_store and ms_seq.
`timescale 1ns / 1ps

module merge_sorter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ms_pkg::data_t value_i,
  input  logic          last_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ms_pkg::data_t value_res_o,
  output logic          last_res_o,
  output logic          truncated_o
);

  ms_pkg::mem_req_t mem_req;
  ms_pkg::data_t    rdata0;
  ms_pkg::data_t    rdata1;
  ms_pkg::res_t     res;
  logic             res_ready;

  logic          out_valid_q;
  ms_pkg::data_t out_value_q;
  logic          out_last_q;
  logic          out_trunc_q;

  // Element store and merge scratch; merges ping-pong between them, reading
  // one and writing the other, so reads and writes never hit the same entry.
  ms_store u_store (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  // Sequencer: loads items, runs the merge passes, then reads the run out.
  ms_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .last_i      (last_i),
    .req_o       (mem_req),
    .rdata0_i    (rdata0),
    .rdata1_i    (rdata1),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register: take a new result when empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  // Payload needs no reset; hold it while a result waits.
  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_value_q <= res.value;
      out_last_q  <= res.last;
      out_trunc_q <= res.trunc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = out_value_q;
  assign last_res_o  = out_last_q;
  assign truncated_o = out_trunc_q;

endmodule

### sv/ms_checker.sv
// Port-level checks for merge_sorter, attached by bind.
// Depends on ms_pkg and merge_sorter.
`timescale 1ns / 1ps

module ms_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          last_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ms_pkg::data_t value_res_o,
  input logic          last_res_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_res_o)
      && $stable(last_res_o))
    else $error("stalled result changed");

  // Stop taking items once the last item of a run is in.
  a_last_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> !in_ready_o)
    else $error("input still open after last item");

  // Keep loading after an item that is not last.
  a_load_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !last_i |=> in_ready_o)
    else $error("input closed in the middle of a run");

  // Keep the input closed while the rest of a run is still being read out.
  a_readout_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_res_o |-> !in_ready_o)
    else $error("input open during readout");

endmodule

bind merge_sorter ms_checker u_ms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_res_o (value_res_o),
  .last_res_o  (last_res_o)
);

### tb/sort_check.sv
`timescale 1ns / 1ps
// Checker for merge_sorter: rebuilds each sorted run from the accepted input
// items and compares every accepted result field by field. Depends on ms_pkg.

module sort_check
  import ms_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_ready_i,
  input  data_t value_i,
  input  logic  last_i,
  input  logic  out_valid_i,
  input  logic  out_ready_i,
  input  data_t value_res_i,
  input  logic  last_res_i,
  input  logic  truncated_i,
  output int    fail_cnt_o,
  output int    pending_o
);

  typedef struct packed {
    data_t value;
    logic  last;
    logic  trunc;
  } sorted_item_t;

  data_t        held_sorted[$];  // current run, kept in ascending order
  logic         held_dropped;
  sorted_item_t due_results[$];
  int           fails;

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_item_t want;
    int           slot;
    if (!rst_ni) begin
      held_sorted.delete();
      due_results.delete();
      held_dropped = 1'b0;
      fails        = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing due: value_res %0d last_res %0b truncated %0b",
                   $time, value_res_i, last_res_i, truncated_i);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (value_res_i !== want.value) begin
            $display("%0t: value_res expected %0d got %0d", $time, want.value, value_res_i);
            fails++;
          end
          if (last_res_i !== want.last) begin
            $display("%0t: last_res expected %0b got %0b", $time, want.last, last_res_i);
            fails++;
          end
          if (truncated_i !== want.trunc) begin
            $display("%0t: truncated expected %0b got %0b", $time, want.trunc, truncated_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        // Insert after any equal values; drop once the store is full.
        if (held_sorted.size() < DEPTH) begin
          slot = 0;
          while (slot < held_sorted.size() && held_sorted[slot] <= value_i) slot++;
          held_sorted.insert(slot, value_i);
        end else begin
          held_dropped = 1'b1;
        end
        if (last_i) begin
          foreach (held_sorted[i]) begin
            want.value = held_sorted[i];
            want.last  = (i == held_sorted.size() - 1);
            want.trunc = held_dropped;
            due_results.push_back(want);
          end
          held_sorted.delete();
          held_dropped = 1'b0;
        end
      end
    end
    fail_cnt_o <= fails;
    pending_o  <= due_results.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for merge_sorter: drives directed and random runs under
// random idling and back-pressure; sort_check predicts and compares.
// Depends on ms_pkg, merge_sorter and sort_check.

module tb;
  import ms_pkg::*;

  localparam int    CYCLE_LIMIT = 200000;  // far above the slowest clean run
  localparam int    HOLD_CYCLES = 600;     // one long receiver hold-off
  localparam int    TAIL_CYCLES = 64;
  localparam int    RAND_ITEMS  = 150;
  localparam data_t VAL_MAX     = 32'sh7fffffff;
  localparam data_t VAL_MIN     = 32'sh80000000;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  data_t value_i     = '0;
  logic  last_i      = 1'b0;
  logic  out_ready_i = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  data_t value_res_o;
  logic  last_res_o;
  logic  truncated_o;

  logic  calm      = 1'b0;  // set: neither side idles
  logic  long_hold = 1'b0;  // set: receiver starts its long hold-off
  int    fail_cnt;
  int    pending;
  int    cycles    = 0;

  always #4 clk_i = ~clk_i;

  merge_sorter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_res_o (value_res_o),
    .last_res_o  (last_res_o),
    .truncated_o (truncated_o)
  );

  sort_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .value_i     (value_i),
    .last_i      (last_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_res_i (value_res_o),
    .last_res_i  (last_res_o),
    .truncated_i (truncated_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  // Mix extremes, a narrow band that makes duplicates, and full-range values.
  function automatic data_t pick_value();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? VAL_MAX : VAL_MIN;
      1, 2, 3: return data_t'(int'($urandom_range(16)) - 8);
      default: return data_t'($urandom);
    endcase
  endfunction

  // Offer one item, maybe after a random idle gap; return at the accepting edge.
  // Call only at a rising edge.
  task automatic send_item(input data_t v, input logic is_last);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold the input idle until every predicted result has come out.
  task automatic wait_runs_out();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Receiver: random stalls, one long hold-off counted here, none while calm.
  initial begin : receiver
    bit hold_served;
    hold_served = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold && !hold_served) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_served = 1'b1;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    data_t mixed_run[6];
    int    sent;
    int    run_idx;
    int    run_len;
    mixed_run = '{-1, 5, -1, 0, VAL_MIN, 5};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-value runs at both extremes: emit unchanged.
    send_item(VAL_MAX, 1'b1);
    send_item(VAL_MIN, 1'b1);
    // Two extremes in reverse order.
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b1);
    // Negatives, zero and duplicates.
    foreach (mixed_run[i]) send_item(mixed_run[i], i == 5);
    // Strictly descending across the sign boundary.
    for (int k = 0; k < 8; k++) send_item(data_t'(300 - 100 * k), k == 7);
    // All equal.
    for (int k = 0; k < 3; k++) send_item(42, k == 2);

    // Pause the sender until the directed runs have drained.
    wait_runs_out();

    // Random runs. A short run followed by a full one while the receiver holds
    // off fills the block and stalls its input; then an over-full run with no
    // idling exercises dropping on a stretch of back-to-back items.
    sent    = 0;
    run_idx = 0;
    while (sent < RAND_ITEMS) begin
      case (run_idx)
        0: run_len = 4;
        1: begin
          run_len   = DEPTH;
          long_hold <= 1'b1;
        end
        2: begin
          run_len = DEPTH + 3;
          calm    <= 1'b1;
        end
        4: begin
          run_len = $urandom_range(10, 1);
          calm    <= 1'b0;
        end
        default: run_len = $urandom_range(10, 1);
      endcase
      for (int k = 0; k < run_len; k++) send_item(pick_value(), k == run_len - 1);
      sent += run_len;
      run_idx++;
    end

    wait_runs_out();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### merge_sorter.f
sv/ms_pkg.sv
sv/ms_store.sv
sv/ms_seq.sv
sv/merge_sorter.sv
sv/ms_checker.sv
tb/sort_check.sv
tb/tb.sv
